[rtl/power_sleep_wake_sequencer_top_defines.svh]
// Assertion macros shared by the power sleep/wake sequencer checker.
`ifndef POWER_SLEEP_WAKE_SEQUENCER_TOP_DEFINES_SVH
`define POWER_SLEEP_WAKE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, held off while reset is low.
`define PSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pss_pkg.sv]
// Package: types, codes and constants of the power sleep/wake sequencer.
package pss_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_W-1:0] SHUTDOWN_TIMEOUT_RST  = 16'd5000;
    localparam logic [CFG_W-1:0] INTERFACE_TIMEOUT_RST = 16'd60000;

    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERFACE_TIMEOUT = 2'd1;

    localparam logic [1:0] REASON_POWER_ON = 2'd0;
    localparam logic [1:0] REASON_ALARM    = 2'd1;
    localparam logic [1:0] REASON_USER     = 2'd2;

    localparam logic [1:0] BTN_NONE = 2'd0;
    localparam logic [1:0] BTN_ZERO = 2'd1;
    localparam logic [1:0] BTN_ONE  = 2'd2;

    typedef enum logic [1:0] {
        MODE_ACTIVE  = 2'd0,
        MODE_SHUTREQ = 2'd1,
        MODE_SLEEP   = 2'd2,
        MODE_UI      = 2'd3
    } t_mode;

    typedef struct packed {
        logic tick;
        logic ev_shutdown_request;
        logic ev_shutdown_abort;
        logic ev_alarm_wake;
        logic ev_user_wake;
        logic ev_button_a;
        logic ev_button_b;
    } t_in_item;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] wake_reason;
        logic       main_rail_on;
        logic       host_rail_on;
        logic       state_announce;
        logic [1:0] button_report;
    } t_out_item;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

endpackage

[rtl/pss_ifs.sv]
// Interfaces: event beat channel in, status beat channel out.
interface pss_in_if import pss_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pss_out_if import pss_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/pss_in_reg.sv]
// Input register: holds one event beat until the sequencer consumes it.
module pss_in_reg import pss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pss_in_if.sink      i_in_ch,
    input  logic        i_take,
    output logic        o_valid,
    output t_in_item    o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign i_in_ch.ready = !r_valid || i_take;
    assign o_valid       = r_valid;
    assign o_item        = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_ch.valid && i_in_ch.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_item <= i_in_ch.data;
        end
    end

endmodule

[rtl/pss_fsm.sv]
// Sequencer state machine: mode, wake reason, dwell timer, rails, timeout registers.
module pss_fsm import pss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  logic      i_valid,
    input  t_in_item  i_item,
    input  logic      i_space,
    output logic      o_take,
    output t_out_item o_result
);

    localparam int CMP_W = ((TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W) + 1;

    t_mode                  r_mode, n_mode;
    logic [1:0]             r_reason, n_reason;
    logic [TIMER_WIDTH-1:0] r_dwell, n_dwell;
    logic                   r_main, n_main;
    logic                   r_host, n_host;
    logic [CFG_W-1:0]       r_shut_tmo, r_ui_tmo;

    logic             ev_any;
    logic             ended;
    logic             hit;
    t_mode            target;
    logic [1:0]       button;
    logic [CFG_W-1:0] limit;
    logic [CMP_W-1:0] dwell_inc;

    assign o_take = i_valid && i_space;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shut_tmo <= SHUTDOWN_TIMEOUT_RST;
            r_ui_tmo   <= INTERFACE_TIMEOUT_RST;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_SHUTDOWN_TIMEOUT:  r_shut_tmo <= i_cfg.data;
                CFG_INTERFACE_TIMEOUT: r_ui_tmo   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ACTIVE;
            r_reason <= REASON_POWER_ON;
            r_dwell  <= '0;
            r_main   <= 1'b1;
            r_host   <= 1'b1;
        end else if (o_take) begin
            r_mode   <= n_mode;
            r_reason <= n_reason;
            r_dwell  <= n_dwell;
            r_main   <= n_main;
            r_host   <= n_host;
        end
    end

    // timeout test: saturated timer or incremented count reaching the limit
    assign limit     = (r_mode == MODE_SHUTREQ) ? r_shut_tmo : r_ui_tmo;
    assign dwell_inc = CMP_W'(r_dwell) + CMP_W'(1);
    assign hit       = (&r_dwell) || (dwell_inc >= CMP_W'(limit));

    always_comb begin
        ev_any   = i_item.ev_shutdown_request || i_item.ev_shutdown_abort ||
                   i_item.ev_alarm_wake || i_item.ev_user_wake ||
                   i_item.ev_button_a || i_item.ev_button_b;
        ended    = ev_any;
        target   = r_mode;
        button   = BTN_NONE;
        n_reason = r_reason;
        n_dwell  = r_dwell;
        n_main   = r_main;
        n_host   = r_host;
        n_mode   = r_mode;

        case (r_mode)
            MODE_ACTIVE: begin
                if (i_item.ev_shutdown_request) begin
                    target = MODE_SHUTREQ;
                end
            end
            MODE_SHUTREQ: begin
                if (ev_any) begin
                    target = (i_item.ev_shutdown_abort || i_item.ev_alarm_wake) ?
                             MODE_ACTIVE : MODE_SLEEP;
                end else if (i_item.tick) begin
                    if (hit) begin
                        ended  = 1'b1;
                        target = MODE_SLEEP;
                    end else begin
                        n_dwell = dwell_inc[TIMER_WIDTH-1:0];
                    end
                end
            end
            MODE_SLEEP: begin
                if (i_item.ev_alarm_wake) begin
                    n_reason = REASON_ALARM;
                    target   = MODE_ACTIVE;
                end else if (i_item.ev_user_wake) begin
                    n_reason = REASON_USER;
                    target   = MODE_ACTIVE;
                end else if (i_item.ev_button_a || i_item.ev_button_b) begin
                    target = MODE_UI;
                end
            end
            MODE_UI: begin
                if (ev_any) begin
                    target = MODE_SLEEP;
                    if (i_item.ev_alarm_wake) begin
                        n_reason = REASON_ALARM;
                        target   = MODE_ACTIVE;
                    end else if (i_item.ev_button_a) begin
                        button = BTN_ZERO;
                    end else if (i_item.ev_button_b) begin
                        button = BTN_ONE;
                    end else if (i_item.ev_user_wake) begin
                        n_reason = REASON_USER;
                        target   = MODE_ACTIVE;
                    end
                end else if (i_item.tick) begin
                    if (hit) begin
                        ended  = 1'b1;
                        target = MODE_SLEEP;
                    end else begin
                        n_dwell = dwell_inc[TIMER_WIDTH-1:0];
                    end
                end
            end
            default: ;
        endcase

        // wait over: clear timer, run rail exit/entry actions on a real change
        if (ended) begin
            n_dwell = '0;
            if (target != r_mode) begin
                if (r_mode == MODE_SLEEP) begin
                    n_main = 1'b1;
                end
                if (target == MODE_SLEEP) begin
                    n_host = 1'b0;
                    n_main = 1'b0;
                end else if (target == MODE_ACTIVE) begin
                    n_host = 1'b1;
                end
                n_mode = target;
            end
        end

        o_result.mode           = n_mode;
        o_result.wake_reason    = n_reason;
        o_result.main_rail_on   = n_main;
        o_result.host_rail_on   = n_host;
        o_result.state_announce = ended;
        o_result.button_report  = button;
    end

endmodule

[rtl/pss_out_reg.sv]
// Result register: holds one status beat until the sink takes it.
module pss_out_reg import pss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_result,
    output logic      o_space,
    pss_out_if.source o_out_ch
);

    logic      r_valid;
    t_out_item r_data;

    assign o_space        = !r_valid || o_out_ch.ready;
    assign o_out_ch.valid = r_valid;
    assign o_out_ch.data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

endmodule

[rtl/power_sleep_wake_sequencer_top.sv]
// Power sleep/wake sequencer: one status beat out for every event beat in, one beat per
// clock sustained while the sink keeps ready; each beat passes the input register, then
// the result register. The four-mode state machine (active, shutdown requested, deep
// sleep, user interface) updates once per beat in a single registered step, which sets
// that throughput. The input register lets one more beat be taken while a status beat
// waits on a stalled sink. Ticks count toward the shutdown and interface timeouts only in
// those two modes and only in beats without an event flag; a timeout register of zero
// behaves as one. The main and host rail enables come out with every status beat; both
// are on after reset and wake reason reads power-on. Timeout registers are written through
// the plain write port (index 0 shutdown, index 1 interface, other indexes ignored); the
// user must write them only while the block is idle, which the block does not enforce.
module power_sleep_wake_sequencer_top import pss_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pss_in_if.sink               i_in_ch,
    pss_out_if.source            o_out_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic      in_valid;
    t_in_item  in_item;
    logic      take;
    logic      space;
    t_out_item result;
    t_cfg_wr   cfg;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // beat holding stage
    pss_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (i_in_ch),
        .i_take  (take),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    // mode decision, rails and timers; steps only when the result register has room
    pss_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (in_valid),
        .i_item   (in_item),
        .i_space  (space),
        .o_take   (take),
        .o_result (result)
    );

    // status beat register
    pss_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_result (result),
        .o_space  (space),
        .o_out_ch (o_out_ch)
    );

endmodule

[rtl/pss_checker.sv]
// Checker on the sequencer's output beats, bound to the top level.
`include "power_sleep_wake_sequencer_top_defines.svh"

module pss_checker import pss_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    `PSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "stalled status beat changed")
    `PSS_ASSERT_SAME(a_sleep_rails_off, i_clk, i_rst_n, i_out_valid && (i_out_data.mode == MODE_SLEEP), !i_out_data.main_rail_on && !i_out_data.host_rail_on, "rail on in deep sleep")
    `PSS_ASSERT_SAME(a_active_rails_on, i_clk, i_rst_n, i_out_valid && (i_out_data.mode == MODE_ACTIVE), i_out_data.main_rail_on && i_out_data.host_rail_on, "rail off in active")
    `PSS_ASSERT_SAME(a_button_to_sleep, i_clk, i_rst_n, i_out_valid && (i_out_data.button_report != BTN_NONE), (i_out_data.mode == MODE_SLEEP) && i_out_data.state_announce, "button report without drop to sleep")

endmodule

bind power_sleep_wake_sequencer_top pss_checker u_pss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_data  (o_out_ch.data)
);
